### sv/i2c_master_write_read_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C write/read sequencer assertion macros
// Concurrent assertion wrappers used by the sequencer top level.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_WRITE_READ_SEQUENCER_MACROS_SVH
`define I2C_MASTER_WRITE_READ_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define I2CWRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");
`define I2CWRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");
`else
`define I2CWRS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2CWRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/i2cwrs_pkg.sv
// ----------------------------------------------------------------------------
// I2C write/read sequencer package
// Shared types, codes and sizes for the transaction sequencer.
// ----------------------------------------------------------------------------
package i2cwrs_pkg;

    localparam int BufDepth = 32;
    localparam int BufAddrW = $clog2(BufDepth);
    localparam int LenW     = 6;
    localparam logic [LenW-1:0] LenMax = LenW'(BufDepth);

    localparam int InDataW  = 40;
    localparam int OutDataW = 48;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_EVENT = 2'd2,
        MODE_TICK  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CMD_NONE         = 3'd0,
        CMD_START        = 3'd1,
        CMD_STOP         = 3'd2,
        CMD_SEND         = 3'd3,
        CMD_RECV_ACK     = 3'd4,
        CMD_RECV_NACK    = 3'd5,
        CMD_STOP_START   = 3'd6,
        CMD_STOP_DISABLE = 3'd7
    } cmd_t;

    localparam logic [7:0] StStart     = 8'h08;
    localparam logic [7:0] StSlawAck   = 8'h18;
    localparam logic [7:0] StDataTxAck = 8'h28;
    localparam logic [7:0] StSlarAck   = 8'h40;
    localparam logic [7:0] StDataRxAck = 8'h50;
    localparam logic [7:0] StDataRxNak = 8'h58;
    localparam logic [7:0] StatusMask  = 8'hF8;

    typedef struct packed {
        mode_t         mode;
        logic [6:0]    address;
        logic [LenW-1:0] write_length;
        logic [LenW-1:0] read_length;
        logic [BufAddrW-1:0] byte_index;
        logic [7:0]    byte_value;
        logic [7:0]    bus_status;
    } item_t;

    typedef struct packed {
        logic          accepted;
        cmd_t          command;
        logic [7:0]    tx_byte;
        logic          read_valid;
        logic [7:0]    read_byte;
        logic [4:0]    read_index;
        logic          done_res;
        logic          success;
        logic          timed_out;
        logic [7:0]    end_status;
        logic [LenW-1:0] read_count;
        logic          idle;
    } result_t;

    typedef struct packed {
        logic                wr_en;
        logic [BufAddrW-1:0] wr_addr;
        logic [7:0]          wr_data;
        logic [BufAddrW-1:0] rd_addr;
    } buf_req_t;

endpackage

### sv/i2c_master_write_read_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master write/read sequencer
// Steps an I2C master through write, read and write-then-read transfers.
//
// Channel   Direction  Handshake           Carries
// s_        in         s_tvalid/s_tready   one request, bus event or tick
// m_        out        m_tvalid/m_tready   one bus command and status result
// cfg_      in         cfg_wr_en           timeout_ticks register
//
// One item is taken per cycle unless a stalled result blocks the input; each
// item passes through the input register, the phase logic and the result
// register, where its result waits until it is taken on m_.
// A stalled result register holds the input register, which then holds s_.
// Synchronous active-low reset returns to idle with timeout_ticks at 100.
// ----------------------------------------------------------------------------
`include "i2c_master_write_read_sequencer_macros.svh"

module i2c_master_write_read_sequencer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [15:0]                        cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // address, write_length, read_length, byte_index, byte_value, bus_status
    input  logic [i2cwrs_pkg::InDataW-1:0]     s_tdata,
    // mode
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // accepted, command, tx_byte, read_valid, read_byte, read_index, done_res,
    // success, timed_out, end_status, read_count, idle, zero padding
    output logic [i2cwrs_pkg::OutDataW-1:0]    m_tdata
);

    i2cwrs_pkg::item_t     in_item;
    i2cwrs_pkg::item_t     in_reg;
    logic                  in_valid_reg;
    i2cwrs_pkg::result_t   res;
    i2cwrs_pkg::result_t   out_reg;
    logic                  out_valid_reg;
    logic [15:0]           tmo_reg;
    logic                  advance;
    logic                  proc;
    i2cwrs_pkg::buf_req_t  buf_req;
    logic [7:0]            buf_rd_data;

    always_comb begin
        in_item.mode         = i2cwrs_pkg::mode_t'(s_tuser);
        in_item.address      = s_tdata[6:0];
        in_item.write_length = s_tdata[12:7];
        in_item.read_length  = s_tdata[18:13];
        in_item.byte_index   = s_tdata[23:19];
        in_item.byte_value   = s_tdata[31:24];
        in_item.bus_status   = s_tdata[39:32];
    end

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign proc     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tmo_reg       <= 16'd100;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_en) begin
                tmo_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= in_item;
        end
        if (proc) begin
            out_reg <= res;
        end
    end

    i2cwrs_wbuf u_wbuf (
        .aclk    (aclk),
        .req     (buf_req),
        .rd_data (buf_rd_data)
    );

    i2cwrs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .proc          (proc),
        .item          (in_reg),
        .timeout_ticks (tmo_reg),
        .buf_rd_data   (buf_rd_data),
        .buf_req       (buf_req),
        .result        (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.idle, out_reg.read_count, out_reg.end_status,
                       out_reg.timed_out, out_reg.success, out_reg.done_res,
                       out_reg.read_index, out_reg.read_byte, out_reg.read_valid,
                       out_reg.tx_byte, out_reg.command, out_reg.accepted};

    // A finished transfer always leaves the sequencer idle.
    `I2CWRS_ASSERT_IMP(a_done_idle, aclk, aresetn, out_valid_reg && out_reg.done_res, out_reg.idle)
    // A taken start request issues a start condition and leaves the sequencer busy.
    `I2CWRS_ASSERT_IMP(a_accept_start, aclk, aresetn,
        out_valid_reg && out_reg.accepted,
        out_reg.command == i2cwrs_pkg::CMD_START && !out_reg.idle)
    // A timeout disables the bus and reports no status.
    `I2CWRS_ASSERT_IMP(a_timeout_cmd, aclk, aresetn,
        out_valid_reg && out_reg.timed_out,
        out_reg.command == i2cwrs_pkg::CMD_STOP_DISABLE
        && out_reg.end_status == 8'h00 && !out_reg.success)
    // An item waiting behind a stalled result is not dropped.
    `I2CWRS_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)

endmodule

### sv/i2cwrs_wbuf.sv
// ----------------------------------------------------------------------------
// I2C write/read sequencer write buffer
// Register file holding the bytes to send, one write and one read port.
// ----------------------------------------------------------------------------
module i2cwrs_wbuf (
    input  logic                          aclk,
    input  i2cwrs_pkg::buf_req_t          req,
    output logic [7:0]                    rd_data
);

    logic [7:0] mem_reg [i2cwrs_pkg::BufDepth];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
    end

    assign rd_data = mem_reg[req.rd_addr];

endmodule

### sv/i2cwrs_ctrl.sv
// ----------------------------------------------------------------------------
// I2C write/read sequencer control
// Phase machine, counters and timeout; forms one result per processed item.
// ----------------------------------------------------------------------------
module i2cwrs_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          proc,
    input  i2cwrs_pkg::item_t             item,
    input  logic [15:0]                   timeout_ticks,
    input  logic [7:0]                    buf_rd_data,
    output i2cwrs_pkg::buf_req_t          buf_req,
    output i2cwrs_pkg::result_t           result
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WSTART = 3'd1,
        PH_SLAW   = 3'd2,
        PH_WDATA  = 3'd3,
        PH_RSTART = 3'd4,
        PH_SLAR   = 3'd5,
        PH_RDATA  = 3'd6
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [6:0]                      addr_reg, addr_next;
    logic [i2cwrs_pkg::LenW-1:0]     wtot_reg, wtot_next;
    logic [i2cwrs_pkg::LenW-1:0]     rtot_reg, rtot_next;
    logic [i2cwrs_pkg::LenW-1:0]     cnt_reg, cnt_next;
    logic [15:0]                     tleft_reg, tleft_next;

    logic [7:0]                      st;
    logic [i2cwrs_pkg::LenW-1:0]     cnt_inc;
    logic [i2cwrs_pkg::LenW:0]       cnt_inc2;

    assign st       = item.bus_status & i2cwrs_pkg::StatusMask;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign cnt_inc2 = {1'b0, cnt_inc} + 1'b1;

    // The buffer index is below the depth by construction, so every load lands.
    always_comb begin
        buf_req.wr_en   = proc && (item.mode == i2cwrs_pkg::MODE_LOAD);
        buf_req.wr_addr = item.byte_index;
        buf_req.wr_data = item.byte_value;
        buf_req.rd_addr = (phase_reg == PH_SLAW) ? '0
                                                 : cnt_reg[i2cwrs_pkg::BufAddrW-1:0];
    end

    always_comb begin
        result     = '0;
        phase_next = phase_reg;
        addr_next  = addr_reg;
        wtot_next  = wtot_reg;
        rtot_next  = rtot_reg;
        cnt_next   = cnt_reg;
        tleft_next = tleft_reg;

        unique case (item.mode)
            i2cwrs_pkg::MODE_START: begin
                if (phase_reg == PH_IDLE) begin
                    addr_next  = item.address;
                    wtot_next  = (item.write_length > i2cwrs_pkg::LenMax)
                                 ? i2cwrs_pkg::LenMax : item.write_length;
                    rtot_next  = (item.read_length > i2cwrs_pkg::LenMax)
                                 ? i2cwrs_pkg::LenMax : item.read_length;
                    cnt_next   = '0;
                    phase_next = (wtot_next != '0) ? PH_WSTART : PH_RSTART;
                    tleft_next = timeout_ticks;
                    result.accepted = 1'b1;
                    result.command  = i2cwrs_pkg::CMD_START;
                end
            end
            i2cwrs_pkg::MODE_LOAD: begin
            end
            i2cwrs_pkg::MODE_EVENT: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_WSTART, PH_RSTART: begin
                        if (st != i2cwrs_pkg::StStart) begin
                            result.command    = i2cwrs_pkg::CMD_STOP;
                            result.done_res   = 1'b1;
                            result.end_status = st;
                            phase_next        = PH_IDLE;
                        end else begin
                            result.command = i2cwrs_pkg::CMD_SEND;
                            result.tx_byte = {addr_reg, phase_reg == PH_RSTART};
                            phase_next     = (phase_reg == PH_WSTART) ? PH_SLAW : PH_SLAR;
                            tleft_next     = timeout_ticks;
                        end
                    end
                    PH_SLAW: begin
                        if (st != i2cwrs_pkg::StSlawAck) begin
                            result.command    = i2cwrs_pkg::CMD_STOP;
                            result.done_res   = 1'b1;
                            result.end_status = st;
                            phase_next        = PH_IDLE;
                        end else begin
                            result.command = i2cwrs_pkg::CMD_SEND;
                            result.tx_byte = buf_rd_data;
                            cnt_next       = i2cwrs_pkg::LenW'(1);
                            phase_next     = PH_WDATA;
                            tleft_next     = timeout_ticks;
                        end
                    end
                    PH_WDATA: begin
                        if (st != i2cwrs_pkg::StDataTxAck) begin
                            result.command    = i2cwrs_pkg::CMD_STOP;
                            result.done_res   = 1'b1;
                            result.end_status = st;
                            phase_next        = PH_IDLE;
                        end else begin
                            tleft_next = timeout_ticks;
                            if (cnt_reg < wtot_reg) begin
                                result.command = i2cwrs_pkg::CMD_SEND;
                                result.tx_byte = buf_rd_data;
                                cnt_next       = cnt_inc;
                            end else if (rtot_reg != '0) begin
                                result.command = i2cwrs_pkg::CMD_STOP_START;
                                phase_next     = PH_RSTART;
                            end else begin
                                result.command    = i2cwrs_pkg::CMD_STOP;
                                result.done_res   = 1'b1;
                                result.success    = 1'b1;
                                result.end_status = st;
                                phase_next        = PH_IDLE;
                            end
                        end
                    end
                    PH_SLAR: begin
                        if (st != i2cwrs_pkg::StSlarAck) begin
                            result.command    = i2cwrs_pkg::CMD_STOP;
                            result.done_res   = 1'b1;
                            result.end_status = st;
                            phase_next        = PH_IDLE;
                        end else begin
                            cnt_next   = '0;
                            tleft_next = timeout_ticks;
                            if (rtot_reg == '0) begin
                                result.command    = i2cwrs_pkg::CMD_STOP;
                                result.done_res   = 1'b1;
                                result.success    = 1'b1;
                                result.end_status = st;
                                phase_next        = PH_IDLE;
                            end else begin
                                result.command = (rtot_reg > i2cwrs_pkg::LenW'(1))
                                                 ? i2cwrs_pkg::CMD_RECV_ACK
                                                 : i2cwrs_pkg::CMD_RECV_NACK;
                                phase_next     = PH_RDATA;
                            end
                        end
                    end
                    PH_RDATA: begin
                        if (st != i2cwrs_pkg::StDataRxAck && st != i2cwrs_pkg::StDataRxNak) begin
                            result.command    = i2cwrs_pkg::CMD_STOP;
                            result.done_res   = 1'b1;
                            result.end_status = st;
                            phase_next        = PH_IDLE;
                        end else begin
                            result.read_valid = 1'b1;
                            result.read_byte  = item.byte_value;
                            result.read_index = cnt_reg[4:0];
                            cnt_next          = cnt_inc;
                            if (cnt_inc < rtot_reg) begin
                                // The last byte of the read is requested with a nack.
                                result.command = (cnt_inc2 < {1'b0, rtot_reg})
                                                 ? i2cwrs_pkg::CMD_RECV_ACK
                                                 : i2cwrs_pkg::CMD_RECV_NACK;
                                tleft_next     = timeout_ticks;
                            end else begin
                                result.command    = i2cwrs_pkg::CMD_STOP;
                                result.done_res   = 1'b1;
                                result.success    = 1'b1;
                                result.end_status = st;
                                result.read_count = cnt_inc;
                                phase_next        = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            i2cwrs_pkg::MODE_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    if (tleft_reg[15:1] == '0) begin
                        tleft_next       = '0;
                        result.command   = i2cwrs_pkg::CMD_STOP_DISABLE;
                        result.done_res  = 1'b1;
                        result.timed_out = 1'b1;
                        phase_next       = PH_IDLE;
                    end else begin
                        tleft_next = tleft_reg - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        result.idle = (phase_next == PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            addr_reg  <= '0;
            wtot_reg  <= '0;
            rtot_reg  <= '0;
            cnt_reg   <= '0;
            tleft_reg <= '0;
        end else if (proc) begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            wtot_reg  <= wtot_next;
            rtot_reg  <= rtot_next;
            cnt_reg   <= cnt_next;
            tleft_reg <= tleft_next;
        end
    end

endmodule

### tb/tb_i2c_master_write_read_sequencer.sv
// ----------------------------------------------------------------------------
// Testbench for the I2C master write/read sequencer
// Drives start requests, buffer loads, bus events and timer ticks into the
// stream input with random gaps and output stalls. Every result is compared
// with the one predicted by a behavioural copy of the sequencer kept here.
// ----------------------------------------------------------------------------
module tb_i2c_master_write_read_sequencer;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cwrs_pkg::*;

    localparam int          QuietLimit = 4000;
    localparam logic [7:0]  StBusError = 8'h00;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_WSTART,
        SEQ_SLAW,
        SEQ_WDATA,
        SEQ_RSTART,
        SEQ_SLAR,
        SEQ_RDATA
    } seq_phase_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [15:0]          cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata     = '0;
    logic [1:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [OutDataW-1:0]  m_tdata;

    // Predicted sequencer state, reset values included.
    logic [15:0]          timeout_reg = 16'd100;
    seq_phase_t           seq_phase   = SEQ_IDLE;
    logic [6:0]           target_addr = '0;
    logic [LenW-1:0]      write_total = '0;
    logic [LenW-1:0]      read_total  = '0;
    logic [LenW-1:0]      byte_count  = '0;
    logic [15:0]          ticks_left  = '0;
    logic [7:0]           write_buf [BufDepth];
    bit                   buf_loaded [BufDepth];

    result_t              results_due[$];
    result_t              seen_result;
    result_t              want_result;
    int unsigned          mismatches  = 0;
    int unsigned          steady_left = 0;
    int unsigned          quiet_cycles = 0;

    i2c_master_write_read_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void end_transfer(inout result_t r, input bit ok,
                                         input logic [7:0] status,
                                         input logic [LenW-1:0] count);
        r.done_res   = 1'b1;
        r.success    = ok;
        r.end_status = status;
        r.read_count = count;
        seq_phase    = SEQ_IDLE;
    endfunction

    function automatic void abort_transfer(inout result_t r, input logic [7:0] status);
        r.command = CMD_STOP;
        end_transfer(r, 1'b0, status, '0);
    endfunction

    function automatic result_t sequencer_step(item_t it);
        result_t    r;
        logic [7:0] st;
        r  = '0;
        st = it.bus_status & StatusMask;
        case (it.mode)
            MODE_START: begin
                if (seq_phase == SEQ_IDLE) begin
                    target_addr = it.address;
                    write_total = (it.write_length > LenMax) ? LenMax : it.write_length;
                    read_total  = (it.read_length > LenMax) ? LenMax : it.read_length;
                    byte_count  = '0;
                    seq_phase   = (write_total != 0) ? SEQ_WSTART : SEQ_RSTART;
                    ticks_left  = timeout_reg;
                    r.accepted  = 1'b1;
                    r.command   = CMD_START;
                end
            end
            MODE_LOAD: begin
                write_buf[it.byte_index]  = it.byte_value;
                buf_loaded[it.byte_index] = 1'b1;
            end
            MODE_EVENT: begin
                case (seq_phase)
                    SEQ_WSTART, SEQ_RSTART: begin
                        if (st != StStart) begin
                            abort_transfer(r, st);
                        end else begin
                            r.command = CMD_SEND;
                            r.tx_byte = {target_addr, seq_phase == SEQ_RSTART};
                            seq_phase = (seq_phase == SEQ_WSTART) ? SEQ_SLAW : SEQ_SLAR;
                            ticks_left = timeout_reg;
                        end
                    end
                    SEQ_SLAW: begin
                        if (st != StSlawAck) begin
                            abort_transfer(r, st);
                        end else begin
                            r.command  = CMD_SEND;
                            r.tx_byte  = write_buf[0];
                            byte_count = LenW'(1);
                            seq_phase  = SEQ_WDATA;
                            ticks_left = timeout_reg;
                        end
                    end
                    SEQ_WDATA: begin
                        if (st != StDataTxAck) begin
                            abort_transfer(r, st);
                        end else begin
                            ticks_left = timeout_reg;
                            if (byte_count < write_total) begin
                                r.command  = CMD_SEND;
                                r.tx_byte  = write_buf[byte_count[BufAddrW-1:0]];
                                byte_count = byte_count + 1'b1;
                            end else if (read_total != 0) begin
                                r.command = CMD_STOP_START;
                                seq_phase = SEQ_RSTART;
                            end else begin
                                r.command = CMD_STOP;
                                end_transfer(r, 1'b1, st, '0);
                            end
                        end
                    end
                    SEQ_SLAR: begin
                        if (st != StSlarAck) begin
                            abort_transfer(r, st);
                        end else begin
                            byte_count = '0;
                            ticks_left = timeout_reg;
                            if (read_total == 0) begin
                                r.command = CMD_STOP;
                                end_transfer(r, 1'b1, st, '0);
                            end else begin
                                r.command = (read_total > 1) ? CMD_RECV_ACK : CMD_RECV_NACK;
                                seq_phase = SEQ_RDATA;
                            end
                        end
                    end
                    SEQ_RDATA: begin
                        if (st != StDataRxAck && st != StDataRxNak) begin
                            abort_transfer(r, st);
                        end else begin
                            r.read_valid = 1'b1;
                            r.read_byte  = it.byte_value;
                            r.read_index = byte_count[4:0];
                            byte_count   = byte_count + 1'b1;
                            if (byte_count < read_total) begin
                                // The last byte of the read phase is requested with a nack.
                                r.command = (int'(byte_count) + 1 < int'(read_total)) ?
                                            CMD_RECV_ACK : CMD_RECV_NACK;
                                ticks_left = timeout_reg;
                            end else begin
                                r.command = CMD_STOP;
                                end_transfer(r, 1'b1, st, byte_count);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_TICK: begin
                if (seq_phase != SEQ_IDLE) begin
                    if (ticks_left <= 1) begin
                        ticks_left  = '0;
                        r.command   = CMD_STOP_DISABLE;
                        r.timed_out = 1'b1;
                        end_transfer(r, 1'b0, '0, '0);
                    end else begin
                        ticks_left = ticks_left - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.idle = (seq_phase == SEQ_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t make_item(mode_t mode, logic [6:0] address,
                                        logic [LenW-1:0] wlen, logic [LenW-1:0] rlen,
                                        logic [BufAddrW-1:0] index, logic [7:0] value,
                                        logic [7:0] status);
        item_t it;
        it.mode         = mode;
        it.address      = address;
        it.write_length = wlen;
        it.read_length  = rlen;
        it.byte_index   = index;
        it.byte_value   = value;
        it.bus_status   = status;
        return it;
    endfunction

    function automatic item_t random_item(mode_t mode);
        return make_item(mode, 7'($urandom_range(0, 127)), LenW'($urandom_range(0, 63)),
                         LenW'($urandom_range(0, 63)),
                         BufAddrW'($urandom_range(0, BufDepth - 1)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_left != 0) begin
            steady_left--;
            return 0;
        end
        if (r < 2) begin
            steady_left = $urandom_range(40, 150);
            return 0;
        end
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly short transfers, some long ones and a few that saturate.
    function automatic logic [LenW-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return LenW'($urandom_range(0, 4));
        if (r < 90)
            return LenW'($urandom_range(5, 32));
        return LenW'($urandom_range(33, 63));
    endfunction

    // The status that moves the sequencer on from its present phase.
    function automatic logic [7:0] status_for_phase();
        case (seq_phase)
            SEQ_WSTART, SEQ_RSTART: return StStart;
            SEQ_SLAW:               return StSlawAck;
            SEQ_WDATA:              return StDataTxAck;
            SEQ_SLAR:               return StSlarAck;
            SEQ_RDATA:              return $urandom_range(0, 1) ? StDataRxAck : StDataRxNak;
            default:                return StBusError;
        endcase
    endfunction

    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {it.bus_status, it.byte_value, it.byte_index,
                     it.read_length, it.write_length, it.address};
        do @(posedge aclk); while (!s_tready);
        results_due.push_back(sequencer_step(it));
    endtask

    // Lets every outstanding result drain, then gives the pipeline time to settle.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_timeout(input logic [15:0] ticks);
        settle_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        timeout_reg = ticks;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    task automatic test_buffer_loads();
        send_item(make_item(MODE_LOAD, 7'd0, 6'd0, 6'd0, 5'd0, 8'hFF, 8'h00));
        send_item(make_item(MODE_LOAD, 7'd127, 6'd63, 6'd63, 5'd31, 8'h00, 8'hFF));
    endtask

    task automatic test_idle_inputs();
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h12, StStart));
        send_item(make_item(MODE_TICK, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, 8'h00));
    endtask

    task automatic test_write_then_read();
        send_item(make_item(MODE_START, 7'd127, 6'd1, 6'd2, 5'd0, 8'h00, 8'h00));
        // A second request while busy must be turned away.
        send_item(make_item(MODE_START, 7'd0, 6'd63, 6'd63, 5'd0, 8'h00, 8'h00));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StStart));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StSlawAck));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StDataTxAck));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StStart));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StSlarAck));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'hA5, StDataRxAck));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h5A, StDataRxNak));
    endtask

    // Low status bits are set on every bus event to show they are masked off.
    task automatic test_single_byte_read();
        send_item(make_item(MODE_START, 7'd0, 6'd0, 6'd1, 5'd0, 8'h00, 8'h00));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StStart | 8'h07));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StSlarAck | 8'h07));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'hFF, StDataRxNak | 8'h07));
    endtask

    task automatic test_zero_lengths();
        send_item(make_item(MODE_START, 7'h55, 6'd0, 6'd0, 5'd0, 8'h00, 8'h00));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StStart));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StSlarAck));
    endtask

    task automatic test_unexpected_status();
        send_item(make_item(MODE_START, 7'h2A, 6'd63, 6'd63, 5'd0, 8'h00, 8'h00));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, StStart));
        send_item(make_item(MODE_EVENT, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, 8'hFF));
    endtask

    task automatic test_timeout_abort();
        program_timeout(16'd1);
        send_item(make_item(MODE_START, 7'h33, 6'd1, 6'd1, 5'd0, 8'h00, 8'h00));
        send_item(make_item(MODE_TICK, 7'd0, 6'd0, 6'd0, 5'd0, 8'h00, 8'h00));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed transfers, with noise on top.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input logic [15:0] ticks, input int unsigned tick_pct,
                                       input int unsigned n_items);
        int unsigned     sent;
        int unsigned     r;
        logic [LenW-1:0] wlen;
        logic [LenW-1:0] rlen;
        logic [LenW-1:0] wsat;
        item_t           it;
        program_timeout(ticks);
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (seq_phase == SEQ_IDLE) begin
                if (r < 70) begin
                    wlen = pick_length();
                    rlen = pick_length();
                    wsat = (wlen > LenMax) ? LenMax : wlen;
                    // Never let a transfer send a buffer entry that has not been loaded.
                    for (int i = 0; i < int'(wsat); i++) begin
                        if (!buf_loaded[i]) begin
                            it = random_item(MODE_LOAD);
                            it.byte_index = BufAddrW'(i);
                            send_item(it);
                        end
                    end
                    it = random_item(MODE_START);
                    it.write_length = wlen;
                    it.read_length  = rlen;
                    send_item(it);
                end else if (r < 85) begin
                    send_item(random_item(MODE_LOAD));
                end else if (r < 93) begin
                    send_item(random_item(MODE_EVENT));
                end else begin
                    send_item(random_item(MODE_TICK));
                end
            end else begin
                if (r < 62) begin
                    it = random_item(MODE_EVENT);
                    it.bus_status = status_for_phase() | 8'($urandom_range(0, 7));
                    send_item(it);
                end else if (r < 62 + tick_pct) begin
                    send_item(random_item(MODE_TICK));
                end else if (r < 70 + tick_pct) begin
                    send_item(random_item(MODE_LOAD));
                end else if (r < 74 + tick_pct) begin
                    send_item(random_item(MODE_START));
                end else begin
                    send_item(random_item(MODE_EVENT));
                end
            end
            sent++;
        end
        // Close any open transfer so that the next register write finds it idle.
        if (seq_phase != SEQ_IDLE) begin
            it = random_item(MODE_EVENT);
            it.bus_status = StBusError;
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ------------------------------------------------------------------
    initial begin
        int unsigned run;
        int unsigned stall;
        int unsigned r;
        forever begin
            r = $urandom_range(0, 99);
            run = (r < 60) ? $urandom_range(1, 8) : $urandom_range(20, 100);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            r = $urandom_range(0, 99);
            stall = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.accepted   = m_tdata[0];
            seen_result.command    = cmd_t'(m_tdata[3:1]);
            seen_result.tx_byte    = m_tdata[11:4];
            seen_result.read_valid = m_tdata[12];
            seen_result.read_byte  = m_tdata[20:13];
            seen_result.read_index = m_tdata[25:21];
            seen_result.done_res   = m_tdata[26];
            seen_result.success    = m_tdata[27];
            seen_result.timed_out  = m_tdata[28];
            seen_result.end_status = m_tdata[36:29];
            seen_result.read_count = m_tdata[42:37];
            seen_result.idle       = m_tdata[43];
            if (results_due.size() == 0) begin
                $error("result transfer arrived with no result expected");
                mismatches++;
            end else begin
                want_result = results_due.pop_front();
                check_field("accepted", want_result.accepted, seen_result.accepted);
                check_field("command", want_result.command, seen_result.command);
                check_field("tx_byte", want_result.tx_byte, seen_result.tx_byte);
                check_field("read_valid", want_result.read_valid, seen_result.read_valid);
                check_field("read_byte", want_result.read_byte, seen_result.read_byte);
                check_field("read_index", want_result.read_index, seen_result.read_index);
                check_field("done_res", want_result.done_res, seen_result.done_res);
                check_field("success", want_result.success, seen_result.success);
                check_field("timed_out", want_result.timed_out, seen_result.timed_out);
                check_field("end_status", want_result.end_status, seen_result.end_status);
                check_field("read_count", want_result.read_count, seen_result.read_count);
                check_field("idle", want_result.idle, seen_result.idle);
            end
        end
    end

    // Ends the run if neither channel completes a transfer for too long.
    initial begin
        wait (aresetn);
        while (quiet_cycles < QuietLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** i2c_master_write_read_sequencer: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_buffer_loads();
        test_idle_inputs();
        test_write_then_read();
        test_single_byte_read();
        test_zero_lengths();
        test_unexpected_status();
        test_timeout_abort();

        test_random_traffic(16'hFFFF, 10, 500);
        test_random_traffic(16'd1, 4, 500);
        test_random_traffic(16'($urandom_range(2, 8)), 25, 500);
        test_random_traffic(16'($urandom_range(9, 300)), 20, 500);

        settle_idle();
        if (mismatches == 0) begin
            $display("** i2c_master_write_read_sequencer: PASSED **");
        end else begin
            $display("** i2c_master_write_read_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
